FILE: rtl/iff_pkg.sv
// Package for the integer field formatter: transaction types, codes and the microcode table.
package iff_pkg;

	localparam int MAX_WIDTH = 63;
	localparam int TXT_DEPTH = 11;

	localparam logic [2:0] CMD_ECHO = 3'd0;
	localparam logic [2:0] CMD_CHAR = 3'd1;
	localparam logic [2:0] CMD_SDEC = 3'd2;
	localparam logic [2:0] CMD_UDEC = 3'd3;
	localparam logic [2:0] CMD_OCT  = 3'd4;
	localparam logic [2:0] CMD_HEX  = 3'd5;

	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_HEX_A = 8'h57;

	localparam logic [31:0] RECIP_10 = 32'hcccccccd;

	localparam logic [3:0] PC_WAIT   = 4'd0;
	localparam logic [3:0] PC_KIND   = 4'd1;
	localparam logic [3:0] PC_MUL    = 4'd2;
	localparam logic [3:0] PC_DIG    = 4'd3;
	localparam logic [3:0] PC_PREP   = 4'd4;
	localparam logic [3:0] PC_CHK_S1 = 4'd5;
	localparam logic [3:0] PC_SIGN1  = 4'd6;
	localparam logic [3:0] PC_CHK_LP = 4'd7;
	localparam logic [3:0] PC_LPAD   = 4'd8;
	localparam logic [3:0] PC_CHK_S2 = 4'd9;
	localparam logic [3:0] PC_SIGN2  = 4'd10;
	localparam logic [3:0] PC_TEXT   = 4'd11;
	localparam logic [3:0] PC_CHK_TP = 4'd12;
	localparam logic [3:0] PC_TPAD   = 4'd13;
	localparam logic [3:0] PC_END    = 4'd14;

	typedef struct packed {
		logic [2:0]  cmd;
		logic        long_mode;
		logic [31:0] value;
		logic [7:0]  min_width;
		logic        left_justify;
		logic        zero_fill;
	} iff_in_t;

	typedef struct packed {
		logic [7:0] out_char;
		logic       last;
	} iff_out_t;

	typedef enum logic [1:0] {
		BASE_DEC,
		BASE_OCT,
		BASE_HEX
	} iff_base_t;

	typedef enum logic [2:0] {
		ACT_NONE,
		ACT_LOAD,
		ACT_MUL,
		ACT_DIGIT,
		ACT_PREP,
		ACT_PAD,
		ACT_POP
	} iff_act_t;

	typedef enum logic [1:0] {
		EMIT_NONE,
		EMIT_SIGN,
		EMIT_FILL,
		EMIT_TEXT
	} iff_emit_t;

	typedef enum logic [3:0] {
		COND_ALWAYS,
		COND_NEVER,
		COND_NOT_ACC,
		COND_IS_CHAR,
		COND_Q_NZ,
		COND_NO_SIGN1,
		COND_NO_LEAD,
		COND_PAD_MORE,
		COND_NO_SIGN2,
		COND_K_MORE,
		COND_NO_TRAIL
	} iff_cond_t;

	typedef struct packed {
		iff_act_t   act;
		iff_emit_t  emit;
		iff_cond_t  cond;
		logic [3:0] target;
	} iff_ctl_t;

	function automatic iff_ctl_t ctl_rom(input logic [3:0] pc);
		iff_ctl_t c;
		c = '{act: ACT_NONE, emit: EMIT_NONE, cond: COND_ALWAYS, target: PC_WAIT};
		case (pc)
			PC_WAIT:   c = '{act: ACT_LOAD,  emit: EMIT_NONE, cond: COND_NOT_ACC,  target: PC_WAIT};
			PC_KIND:   c = '{act: ACT_NONE,  emit: EMIT_NONE, cond: COND_IS_CHAR,  target: PC_PREP};
			PC_MUL:    c = '{act: ACT_MUL,   emit: EMIT_NONE, cond: COND_NEVER,    target: PC_WAIT};
			PC_DIG:    c = '{act: ACT_DIGIT, emit: EMIT_NONE, cond: COND_Q_NZ,     target: PC_MUL};
			PC_PREP:   c = '{act: ACT_PREP,  emit: EMIT_NONE, cond: COND_NEVER,    target: PC_WAIT};
			PC_CHK_S1: c = '{act: ACT_NONE,  emit: EMIT_NONE, cond: COND_NO_SIGN1, target: PC_CHK_LP};
			PC_SIGN1:  c = '{act: ACT_NONE,  emit: EMIT_SIGN, cond: COND_NEVER,    target: PC_WAIT};
			PC_CHK_LP: c = '{act: ACT_NONE,  emit: EMIT_NONE, cond: COND_NO_LEAD,  target: PC_CHK_S2};
			PC_LPAD:   c = '{act: ACT_PAD,   emit: EMIT_FILL, cond: COND_PAD_MORE, target: PC_LPAD};
			PC_CHK_S2: c = '{act: ACT_NONE,  emit: EMIT_NONE, cond: COND_NO_SIGN2, target: PC_TEXT};
			PC_SIGN2:  c = '{act: ACT_NONE,  emit: EMIT_SIGN, cond: COND_NEVER,    target: PC_WAIT};
			PC_TEXT:   c = '{act: ACT_POP,   emit: EMIT_TEXT, cond: COND_K_MORE,   target: PC_TEXT};
			PC_CHK_TP: c = '{act: ACT_NONE,  emit: EMIT_NONE, cond: COND_NO_TRAIL, target: PC_WAIT};
			PC_TPAD:   c = '{act: ACT_PAD,   emit: EMIT_FILL, cond: COND_PAD_MORE, target: PC_TPAD};
			PC_END:    c = '{act: ACT_NONE,  emit: EMIT_NONE, cond: COND_ALWAYS,   target: PC_WAIT};
			default:   c = '{act: ACT_NONE,  emit: EMIT_NONE, cond: COND_ALWAYS,   target: PC_WAIT};
		endcase
		return c;
	endfunction

	function automatic logic [7:0] digit_char(input logic [3:0] d);
		return (d < 4'd10) ? (CH_ZERO + {4'd0, d}) : (CH_HEX_A + {4'd0, d});
	endfunction

endpackage

FILE: rtl/integer_field_formatter.sv
// Integer field formatter top level: microcoded sequencer formatting one conversion per transaction.
//
//  channel | dir | type               | handshake
//  cmd     | in  | iff_pkg::iff_in_t  | cmd_valid / cmd_ready
//  chr     | out | iff_pkg::iff_out_t | chr_valid / chr_ready
//
// A transaction runs N + 2*D + 7 microcode steps, one more with trailing padding:
// N characters, D digits (none for character kinds), each digit two microcode steps through
// the shared divide-by-base datapath, one step per emitted character, plus seven fixed steps.
// cmd_ready is high only while the sequencer waits at its first step.
// arst_n clears the step counter and the output valid; payload registers are not reset.
// A stall on chr_ready holds the sequencer at its emit step until the slot frees.
module integer_field_formatter #(
	parameter int MAX_WIDTH = iff_pkg::MAX_WIDTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	output logic              cmd_ready,
	input  iff_pkg::iff_in_t  cmd_data,
	output logic              chr_valid,
	input  logic              chr_ready,
	output iff_pkg::iff_out_t chr_data
);

	logic [3:0]         pc_q;
	logic [3:0]         pc_d;
	iff_pkg::iff_ctl_t  ctl;

	logic               chr_valid_q;
	iff_pkg::iff_out_t  chr_data_q;

	iff_pkg::iff_base_t base_q;
	logic               is_char_q;
	logic               neg_q;
	logic               zf_q;
	logic               lj_q;
	logic [5:0]         w_q;
	logic [31:0]        mag_q;
	logic [63:0]        prod_q;
	logic [7:0]         txt_q [iff_pkg::TXT_DEPTH];
	logic [3:0]         k_q;
	logic [5:0]         pad_q;
	logic [5:0]         rem_q;

	logic               accept;
	logic               slot_free;
	logic               go;
	logic               emit_fire;
	logic               cond_true;
	logic [31:0]        quo;
	logic [31:0]        quo10;
	logic [31:0]        rem_dec;
	logic [3:0]         digit;
	logic [3:0]         top_idx;
	logic [4:0]         need;
	logic [5:0]         total;
	logic [7:0]         emit_char;
	logic               is_echo;
	logic               is_num;
	logic [31:0]        mag_in;
	logic               neg_in;

	assign ctl       = iff_pkg::ctl_rom(pc_q);
	assign cmd_ready = (ctl.act == iff_pkg::ACT_LOAD);
	assign accept    = cmd_valid && cmd_ready;
	assign slot_free = !chr_valid_q || chr_ready;
	assign go        = (ctl.emit == iff_pkg::EMIT_NONE) || slot_free;
	assign emit_fire = (ctl.emit != iff_pkg::EMIT_NONE) && slot_free;
	assign chr_valid = chr_valid_q;
	assign chr_data  = chr_data_q;
	assign top_idx   = k_q - 4'd1;

	always_comb begin
		is_echo = (cmd_data.cmd == iff_pkg::CMD_ECHO) || (cmd_data.cmd > iff_pkg::CMD_HEX);
		is_num  = !is_echo && (cmd_data.cmd != iff_pkg::CMD_CHAR);
		mag_in  = cmd_data.long_mode ? cmd_data.value : {16'd0, cmd_data.value[15:0]};
		neg_in  = 1'b0;
		if (cmd_data.cmd == iff_pkg::CMD_SDEC) begin
			if (cmd_data.long_mode && cmd_data.value[31]) begin
				neg_in = 1'b1;
				mag_in = ~cmd_data.value + 32'd1;
			end else if (!cmd_data.long_mode && cmd_data.value[15]) begin
				neg_in = 1'b1;
				mag_in = 32'h0001_0000 - {16'd0, cmd_data.value[15:0]};
			end
		end
	end

	always_comb begin
		case (base_q)
			iff_pkg::BASE_OCT: begin
				quo   = {3'd0, mag_q[31:3]};
				digit = {1'b0, mag_q[2:0]};
			end
			iff_pkg::BASE_HEX: begin
				quo   = {4'd0, mag_q[31:4]};
				digit = mag_q[3:0];
			end
			default: begin
				quo   = {3'd0, prod_q[63:35]};
				digit = rem_dec[3:0];
			end
		endcase
	end

	assign quo10   = {quo[28:0], 3'd0} + {quo[30:0], 1'b0};
	assign rem_dec = mag_q - quo10;

	assign need  = {1'b0, k_q} + {4'd0, neg_q};
	assign total = (w_q > {1'b0, need}) ? w_q : {1'b0, need};

	always_comb begin
		case (ctl.emit)
			iff_pkg::EMIT_SIGN: emit_char = iff_pkg::CH_MINUS;
			iff_pkg::EMIT_FILL: emit_char = zf_q ? iff_pkg::CH_ZERO : iff_pkg::CH_SPACE;
			iff_pkg::EMIT_TEXT: emit_char = txt_q[top_idx];
			default:            emit_char = iff_pkg::CH_SPACE;
		endcase
	end

	always_comb begin
		case (ctl.cond)
			iff_pkg::COND_ALWAYS:   cond_true = 1'b1;
			iff_pkg::COND_NEVER:    cond_true = 1'b0;
			iff_pkg::COND_NOT_ACC:  cond_true = !accept;
			iff_pkg::COND_IS_CHAR:  cond_true = is_char_q;
			iff_pkg::COND_Q_NZ:     cond_true = (quo != 32'd0);
			iff_pkg::COND_NO_SIGN1: cond_true = !(neg_q && zf_q);
			iff_pkg::COND_NO_LEAD:  cond_true = lj_q || (pad_q == 6'd0);
			iff_pkg::COND_PAD_MORE: cond_true = (pad_q != 6'd1);
			iff_pkg::COND_NO_SIGN2: cond_true = !(neg_q && !zf_q);
			iff_pkg::COND_K_MORE:   cond_true = (k_q != 4'd1);
			iff_pkg::COND_NO_TRAIL: cond_true = !lj_q || (pad_q == 6'd0);
			default:                cond_true = 1'b1;
		endcase
	end

	always_comb begin
		pc_d = pc_q;
		if (go) begin
			pc_d = cond_true ? ctl.target : (pc_q + 4'd1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q        <= iff_pkg::PC_WAIT;
			chr_valid_q <= 1'b0;
		end else begin
			pc_q <= pc_d;
			if (emit_fire) begin
				chr_valid_q <= 1'b1;
			end else if (chr_ready) begin
				chr_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit_fire) begin
			chr_data_q.out_char <= emit_char;
			chr_data_q.last     <= (rem_q == 6'd1);
			rem_q               <= rem_q - 6'd1;
		end
		if (go) begin
			case (ctl.act)
				iff_pkg::ACT_LOAD: begin
					if (accept) begin
						is_char_q <= !is_num;
						neg_q     <= neg_in;
						zf_q      <= is_num && cmd_data.zero_fill;
						lj_q      <= cmd_data.left_justify;
						mag_q     <= mag_in;
						if (is_echo || (cmd_data.min_width > 8'(MAX_WIDTH))) begin
							w_q <= 6'd0;
						end else begin
							w_q <= cmd_data.min_width[5:0];
						end
						if (cmd_data.cmd == iff_pkg::CMD_OCT) begin
							base_q <= iff_pkg::BASE_OCT;
						end else if (cmd_data.cmd == iff_pkg::CMD_HEX) begin
							base_q <= iff_pkg::BASE_HEX;
						end else begin
							base_q <= iff_pkg::BASE_DEC;
						end
						if (is_num) begin
							k_q <= 4'd0;
						end else begin
							txt_q[0] <= cmd_data.value[7:0];
							k_q      <= 4'd1;
						end
					end
				end
				iff_pkg::ACT_MUL: begin
					prod_q <= mag_q * iff_pkg::RECIP_10;
				end
				iff_pkg::ACT_DIGIT: begin
					txt_q[k_q] <= iff_pkg::digit_char(digit);
					k_q        <= k_q + 4'd1;
					mag_q      <= quo;
				end
				iff_pkg::ACT_PREP: begin
					pad_q <= total - {1'b0, need};
					rem_q <= total;
				end
				iff_pkg::ACT_PAD: begin
					pad_q <= pad_q - 6'd1;
				end
				iff_pkg::ACT_POP: begin
					k_q <= k_q - 4'd1;
				end
				default: begin
				end
			endcase
		end
	end

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 1ps
// Testbench for integer_field_formatter: directed and random conversions checked per character.
module testbench;

	localparam string DIGITS = "0123456789abcdef";

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cmd_valid = 1'b0;
	logic              cmd_ready;
	iff_pkg::iff_in_t  cmd_data = '0;
	logic              chr_valid;
	logic              chr_ready = 1'b0;
	iff_pkg::iff_out_t chr_data;

	iff_pkg::iff_out_t expected_chars[$];
	int                error_count = 0;
	int                hold_cycles = 0;
	bit                steady = 1'b0;

	integer_field_formatter u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd_data  (cmd_data),
		.chr_valid (chr_valid),
		.chr_ready (chr_ready),
		.chr_data  (chr_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Expected characters for one conversion, appended to expected_chars.
	function automatic void format_conversion(input iff_pkg::iff_in_t c);
		logic [7:0]  text[$];
		logic [7:0]  line[$];
		logic [31:0] mag;
		logic [31:0] base;
		logic [7:0]  fill;
		logic        neg;
		int          w;
		int          lead;
		neg = 1'b0;
		lead = 0;
		fill = c.zero_fill ? iff_pkg::CH_ZERO : iff_pkg::CH_SPACE;
		if (c.cmd == iff_pkg::CMD_ECHO || c.cmd > iff_pkg::CMD_HEX) begin
			expected_chars.push_back(iff_pkg::iff_out_t'{out_char: c.value[7:0], last: 1'b1});
			return;
		end
		if (c.cmd == iff_pkg::CMD_CHAR) begin
			text.push_back(c.value[7:0]);
			fill = iff_pkg::CH_SPACE;
		end else begin
			mag = c.long_mode ? c.value : {16'd0, c.value[15:0]};
			if (c.cmd == iff_pkg::CMD_SDEC) begin
				if (c.long_mode && c.value[31]) begin
					neg = 1'b1;
					mag = ~c.value + 32'd1;
				end else if (!c.long_mode && c.value[15]) begin
					neg = 1'b1;
					mag = 32'h10000 - mag;
				end
			end
			base = (c.cmd <= iff_pkg::CMD_UDEC) ? 32'd10 :
				((c.cmd == iff_pkg::CMD_OCT) ? 32'd8 : 32'd16);
			do begin
				text.push_front(DIGITS[mag % base]);
				mag = mag / base;
			end while (mag != 0);
		end
		w = int'(c.min_width);
		if (w > iff_pkg::MAX_WIDTH)
			w = 0;
		if (w != 0)
			lead = w - text.size() - (neg ? 1 : 0);
		if (neg && fill == iff_pkg::CH_ZERO)
			line.push_back(iff_pkg::CH_MINUS);
		if (!c.left_justify)
			for (int i = 0; i < lead; i++)
				line.push_back(fill);
		if (neg && fill == iff_pkg::CH_SPACE)
			line.push_back(iff_pkg::CH_MINUS);
		foreach (text[i])
			line.push_back(text[i]);
		if (c.left_justify)
			for (int i = 0; i < lead; i++)
				line.push_back(fill);
		foreach (line[i])
			expected_chars.push_back(iff_pkg::iff_out_t'{out_char: line[i],
				last: (i == line.size() - 1)});
	endfunction

	function automatic iff_pkg::iff_in_t make_conversion(input logic [2:0] cmd, input logic lm,
			input logic [31:0] value, input logic [7:0] w, input logic lj, input logic zf);
		iff_pkg::iff_in_t c;
		c = '{cmd: cmd, long_mode: lm, value: value, min_width: w, left_justify: lj,
			zero_fill: zf};
		return c;
	endfunction

	function automatic iff_pkg::iff_in_t random_conversion();
		iff_pkg::iff_in_t c;
		int unsigned      r;
		r = $urandom_range(0, 15);
		c.cmd = (r < 8) ? 3'(r) : 3'($urandom_range(2, 5));
		c.long_mode = 1'($urandom_range(0, 1));
		c.left_justify = 1'($urandom_range(0, 1));
		c.zero_fill = 1'($urandom_range(0, 1));
		case ($urandom_range(0, 7))
			0: c.value = $urandom_range(0, 15);
			1: c.value = {16'($urandom_range(0, 65535)), 16'h8000} +
				32'($urandom_range(0, 3)) - 32'd2;
			2: c.value = 32'h80000000 + 32'($urandom_range(0, 3)) - 32'd2;
			3: c.value = $urandom_range(0, 1) ? 32'hffffffff : 32'h0;
			default: c.value = $urandom;
		endcase
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5: c.min_width = 8'($urandom_range(0, 16));
			6, 7: c.min_width = 8'($urandom_range(17, 63));
			8: c.min_width = 8'(iff_pkg::MAX_WIDTH + $urandom_range(0, 1));
			default: c.min_width = 8'($urandom_range(0, 255));
		endcase
		return c;
	endfunction

	task automatic send_conversion(input iff_pkg::iff_in_t item);
		@(negedge clk);
		while (!steady && $urandom_range(0, 99) < 26) begin
			cmd_valid <= 1'b0;
			@(negedge clk);
		end
		cmd_valid <= 1'b1;
		cmd_data <= item;
		@(posedge clk);
		while (!cmd_ready)
			@(posedge clk);
		format_conversion(item);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		cmd_valid <= 1'b0;
		while (expected_chars.size() != 0)
			@(posedge clk);
	endtask

	// Receiver: random stalls, plus a counted hold-off on request.
	initial begin
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				chr_ready <= 1'b0;
				hold_cycles--;
			end else begin
				chr_ready <= steady ? 1'b1 : ($urandom_range(0, 99) >= 26);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && chr_valid && chr_ready) begin
			if (expected_chars.size() == 0) begin
				error_count++;
				if (error_count <= 10)
					$display("unexpected character %02h last %0b with nothing pending",
						chr_data.out_char, chr_data.last);
			end else begin
				if (chr_data.out_char !== expected_chars[0].out_char ||
						chr_data.last !== expected_chars[0].last) begin
					error_count++;
					if (error_count <= 10)
						$display("mismatch: expected char %02h last %0b, got char %02h last %0b",
							expected_chars[0].out_char, expected_chars[0].last,
							chr_data.out_char, chr_data.last);
				end
				void'(expected_chars.pop_front());
			end
		end
	end

	task automatic test_char_kinds();
		send_conversion(make_conversion(iff_pkg::CMD_ECHO, 1'b0, 32'h00000041, 8'd20, 1'b0, 1'b1));
		send_conversion(make_conversion(iff_pkg::CMD_ECHO, 1'b1, 32'hffffffff, 8'd255, 1'b1, 1'b1));
		send_conversion(make_conversion(3'd6, 1'b0, 32'h00000055, 8'd0, 1'b0, 1'b0));
		send_conversion(make_conversion(3'd7, 1'b1, 32'h123456aa, 8'd10, 1'b1, 1'b0));
		send_conversion(make_conversion(iff_pkg::CMD_CHAR, 1'b0, 32'hffffff00, 8'd5, 1'b0, 1'b1));
		send_conversion(make_conversion(iff_pkg::CMD_CHAR, 1'b1, 32'h000000ff, 8'd5, 1'b1, 1'b1));
	endtask

	task automatic test_number_extremes();
		send_conversion(make_conversion(iff_pkg::CMD_SDEC, 1'b0, 32'h00008000, 8'd0, 1'b0, 1'b0));
		send_conversion(make_conversion(iff_pkg::CMD_SDEC, 1'b1, 32'h80000000, 8'd0, 1'b0, 1'b0));
		send_conversion(make_conversion(iff_pkg::CMD_SDEC, 1'b0, 32'hffff7fff, 8'd0, 1'b0, 1'b0));
		send_conversion(make_conversion(iff_pkg::CMD_SDEC, 1'b1, 32'hffffffff, 8'd0, 1'b0, 1'b0));
		send_conversion(make_conversion(iff_pkg::CMD_UDEC, 1'b1, 32'hffffffff, 8'd0, 1'b0, 1'b0));
		send_conversion(make_conversion(iff_pkg::CMD_UDEC, 1'b0, 32'h00000000, 8'd0, 1'b0, 1'b0));
		send_conversion(make_conversion(iff_pkg::CMD_OCT, 1'b1, 32'hffffffff, 8'd0, 1'b0, 1'b0));
		send_conversion(make_conversion(iff_pkg::CMD_HEX, 1'b1, 32'hdeadbeef, 8'd0, 1'b0, 1'b0));
		send_conversion(make_conversion(iff_pkg::CMD_HEX, 1'b0, 32'habcd1234, 8'd0, 1'b0, 1'b0));
	endtask

	task automatic test_field_widths();
		send_conversion(make_conversion(iff_pkg::CMD_SDEC, 1'b0, 32'h0000fffb, 8'd8, 1'b0, 1'b1));
		send_conversion(make_conversion(iff_pkg::CMD_SDEC, 1'b0, 32'h0000fffb, 8'd8, 1'b0, 1'b0));
		send_conversion(make_conversion(iff_pkg::CMD_SDEC, 1'b1, 32'hfffffffb, 8'd8, 1'b1, 1'b1));
		send_conversion(make_conversion(iff_pkg::CMD_UDEC, 1'b0, 32'd123, 8'd63, 1'b1, 1'b0));
		send_conversion(make_conversion(iff_pkg::CMD_UDEC, 1'b0, 32'd123, 8'd64, 1'b0, 1'b1));
		send_conversion(make_conversion(iff_pkg::CMD_UDEC, 1'b0, 32'd123, 8'd255, 1'b0, 1'b0));
		send_conversion(make_conversion(iff_pkg::CMD_HEX, 1'b1, 32'hffffffff, 8'd4, 1'b0, 1'b1));
		send_conversion(make_conversion(iff_pkg::CMD_OCT, 1'b0, 32'h00000000, 8'd1, 1'b0, 1'b1));
		send_conversion(make_conversion(iff_pkg::CMD_SDEC, 1'b1, 32'h80000000, 8'd63, 1'b0, 1'b0));
		wait_drained();
	endtask

	task automatic test_receiver_holdoff();
		hold_cycles = 400;
		for (int i = 0; i < 16; i++)
			send_conversion(make_conversion(3'($urandom_range(1, 5)), 1'b1, $urandom,
				8'($urandom_range(20, 63)), 1'($urandom_range(0, 1)),
				1'($urandom_range(0, 1))));
		wait_drained();
	endtask

	task automatic test_random_conversions();
		steady = 1'b1;
		for (int i = 0; i < 120; i++)
			send_conversion(random_conversion());
		steady = 1'b0;
		for (int i = 0; i < 360; i++)
			send_conversion(random_conversion());
		wait_drained();
	endtask

	initial begin
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		test_char_kinds();
		test_number_extremes();
		test_field_widths();
		test_receiver_holdoff();
		test_random_conversions();
		repeat (150) @(posedge clk);
		if (error_count == 0 && expected_chars.size() == 0) begin
			$display("testbench: PASS");
		end else begin
			if (expected_chars.size() != 0)
				$display("%0d expected characters never arrived", expected_chars.size());
			$display("testbench: FAIL");
		end
		$finish;
	end

	initial begin
		#4000000;
		$display("timeout with %0d characters pending", expected_chars.size());
		$display("testbench: FAIL");
		$finish;
	end

endmodule
